// ===== rtl/tpcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tpcs_pkg;

   localparam int PACKET_LENGTH = 188;
   localparam int WIN_BITS      = $clog2(PACKET_LENGTH);
   localparam int POS_BITS      = $clog2(PACKET_LENGTH + 1);
   localparam int TGT_BITS      = 9;
   localparam int PID_ENTRIES   = 8192;
   localparam int PID_BITS      = $clog2(PID_ENTRIES);
   localparam int COUNT_BITS    = 24;
   localparam int COUNT_OUT     = 24;

   localparam logic [7:0]          SYNC_BYTE = 8'h47;
   localparam logic [PID_BITS-1:0] STUFF_PID = PID_BITS'(13'h1FFF);

   localparam logic [2:0] TYPE_NONE      = 3'd0;
   localparam logic [2:0] TYPE_SECTION   = 3'd1;
   localparam logic [2:0] TYPE_PES       = 3'd2;
   localparam logic [2:0] TYPE_SCRAMBLED = 3'd3;
   localparam logic [2:0] TYPE_STUFFING  = 3'd4;
   localparam logic [2:0] TYPE_UNKNOWN   = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_of_buffer;
   } req_type;

   typedef struct packed {
      logic                 record_valid;
      logic [12:0]          packet_pid;
      logic [COUNT_OUT-1:0] packet_count;
      logic [2:0]           content_type;
      logic [7:0]           content_id;
      logic                 newly_examined;
      logic                 buffer_done;
      logic                 buffer_found;
   } rsp_type;

   typedef struct packed {
      logic [PID_BITS-1:0] pid;
      logic                ex_set;
      logic [2:0]          ex_type;
      logic [7:0]          ex_id;
   } parse_res_type;

   // one packet or buffer-end event handed from front to back
   typedef struct packed {
      logic          pkt;
      logic          done;
      parse_res_type res;
   } rec_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [2:0]            ctype;
      logic [7:0]            cid;
   } tbl_entry_type;

   typedef enum logic [2:0] {
      PH_HDR, PH_ADAPT, PH_J, PH_J1, PH_J2, PH_J3, PH_SEC, PH_DONE
   } parse_phase_type;

   typedef enum logic [1:0] {
      BK_CLEAR, BK_IDLE, BK_UPDATE
   } back_state_type;

endpackage
`default_nettype wire

// ===== rtl/ts_pid_content_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Transport stream PID scanner. Takes one stream byte per cycle while locked to
// packets or while searching the 188-byte window, unless the record queue is
// full. When the search finds a confirmed sync, or a buffer ends during the
// search, the window memory is read back through the packet parser, one byte a
// cycle, with full held high while it runs. Each packet count and each
// buffer-end result then takes one read and, for a packet, one write of the
// 8192-entry PID table in the back end; a four-deep record queue absorbs them.
// After reset all 8192 PID table entries are cleared, with full held high.
module ts_pid_content_scanner (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire tpcs_pkg::req_type req_data,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output tpcs_pkg::rsp_type      rsp_data
);

   logic              clearing;
   logic              rq_room, rq_push, rq_pop, rq_valid;
   tpcs_pkg::rec_type rq_in, rq_head;

   tpcs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .hold     (clearing),
      .rec_room (rq_room),
      .rec_push (rq_push),
      .rec_data (rq_in)
   );

   tpcs_rec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_data (rq_in),
      .room      (rq_room),
      .pop       (rq_pop),
      .not_empty (rq_valid),
      .head_data (rq_head)
   );

   tpcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (rq_valid),
      .rec_data  (rq_head),
      .rec_pop   (rq_pop),
      .clearing  (clearing),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rq_push |-> rq_room)
      else $error("record queue overflow");

   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_full)
      else $error("byte accepted during table clear");

   a_empty_record_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.record_valid) |->
         (rsp_data.packet_count == '0 && rsp_data.content_type == tpcs_pkg::TYPE_NONE
          && rsp_data.newly_examined == 1'b0))
      else $error("packet fields set on a buffer-end transaction");

   a_found_only_at_done: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.buffer_found) |-> rsp_data.buffer_done)
      else $error("buffer_found without buffer_done");

endmodule
`default_nettype wire

// ===== rtl/tpcs_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tpcs_parser (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           feed,
   input  wire logic [tpcs_pkg::POS_BITS-1:0]  pos,
   input  wire logic [7:0]                     data_in,
   output tpcs_pkg::parse_res_type             result
);

   tpcs_pkg::parse_phase_type          phase_ff, phase_in;
   tpcs_pkg::parse_phase_type          cur_phase;
   logic                               tei_ff, tei_in;
   logic                               pusi_ff, pusi_in;
   logic                               afc0_ff, afc0_in;
   logic [tpcs_pkg::PID_BITS-1:0]      pid_ff, pid_in;
   logic [tpcs_pkg::TGT_BITS-1:0]      tgt_ff, tgt_in;
   logic                               ex_set_ff, ex_set_in;
   logic [2:0]                         ex_type_ff, ex_type_in;
   logic [7:0]                         ex_id_ff, ex_id_in;
   logic                               hit;

   assign hit = (tpcs_pkg::TGT_BITS'(pos) == tgt_ff);
   // the sync byte of a packet entered through a lock is never fed, so the
   // header always restarts at position one
   assign cur_phase = (pos == tpcs_pkg::POS_BITS'(1)) ? tpcs_pkg::PH_HDR : phase_ff;

   always_comb begin
      phase_in   = phase_ff;
      tei_in     = tei_ff;
      pusi_in    = pusi_ff;
      afc0_in    = afc0_ff;
      pid_in     = pid_ff;
      tgt_in     = tgt_ff;
      ex_set_in  = ex_set_ff;
      ex_type_in = ex_type_ff;
      ex_id_in   = ex_id_ff;
      if (feed) begin
         if (pos == '0) begin
            phase_in   = tpcs_pkg::PH_HDR;
            ex_set_in  = 1'b0;
            ex_type_in = tpcs_pkg::TYPE_NONE;
            ex_id_in   = '0;
         end else begin
            if (pos == tpcs_pkg::POS_BITS'(1)) begin
               phase_in   = tpcs_pkg::PH_HDR;
               ex_set_in  = 1'b0;
               ex_type_in = tpcs_pkg::TYPE_NONE;
               ex_id_in   = '0;
            end
            case (cur_phase)
               tpcs_pkg::PH_HDR: begin
                  if (pos == tpcs_pkg::POS_BITS'(1)) begin
                     tei_in  = data_in[7];
                     pusi_in = data_in[6];
                     pid_in  = {data_in[4:0], pid_ff[7:0]};
                  end else if (pos == tpcs_pkg::POS_BITS'(2)) begin
                     pid_in = {pid_ff[12:8], data_in};
                  end else begin
                     if (tei_ff) begin
                        phase_in = tpcs_pkg::PH_DONE;
                     end else if (data_in[7:6] != 2'b00) begin
                        ex_set_in  = 1'b1;
                        ex_type_in = tpcs_pkg::TYPE_SCRAMBLED;
                        phase_in   = tpcs_pkg::PH_DONE;
                     end else if (pusi_ff) begin
                        ex_set_in  = 1'b1;
                        ex_type_in = tpcs_pkg::TYPE_UNKNOWN;
                        afc0_in    = data_in[4];
                        if (data_in[5]) begin
                           phase_in = tpcs_pkg::PH_ADAPT;
                        end else if (data_in[4]) begin
                           phase_in = tpcs_pkg::PH_J;
                           tgt_in   = tpcs_pkg::TGT_BITS'(4);
                        end else begin
                           phase_in = tpcs_pkg::PH_DONE;
                        end
                     end else begin
                        if (pid_ff == tpcs_pkg::STUFF_PID) begin
                           ex_set_in  = 1'b1;
                           ex_type_in = tpcs_pkg::TYPE_STUFFING;
                        end
                        phase_in = tpcs_pkg::PH_DONE;
                     end
                  end
               end
               tpcs_pkg::PH_ADAPT: begin
                  tgt_in   = tpcs_pkg::TGT_BITS'(5) + tpcs_pkg::TGT_BITS'(data_in);
                  phase_in = afc0_ff ? tpcs_pkg::PH_J : tpcs_pkg::PH_DONE;
               end
               tpcs_pkg::PH_J: begin
                  if (hit) begin
                     if (data_in == 8'd0) begin
                        phase_in = tpcs_pkg::PH_J1;
                        tgt_in   = tgt_ff + 1'b1;
                     end else begin
                        phase_in = tpcs_pkg::PH_SEC;
                        tgt_in   = tgt_ff + tpcs_pkg::TGT_BITS'(data_in) + 1'b1;
                     end
                  end
               end
               tpcs_pkg::PH_J1: begin
                  if (hit) begin
                     if (data_in == 8'd0) begin
                        phase_in = tpcs_pkg::PH_J2;
                        tgt_in   = tgt_ff + 1'b1;
                     end else begin
                        ex_type_in = tpcs_pkg::TYPE_SECTION;
                        ex_id_in   = data_in;
                        phase_in   = tpcs_pkg::PH_DONE;
                     end
                  end
               end
               tpcs_pkg::PH_J2: begin
                  if (hit) begin
                     if (data_in == 8'd1) begin
                        phase_in = tpcs_pkg::PH_J3;
                        tgt_in   = tgt_ff + 1'b1;
                     end else begin
                        // pointer field was zero: table id is the zero byte after it
                        ex_type_in = tpcs_pkg::TYPE_SECTION;
                        ex_id_in   = 8'd0;
                        phase_in   = tpcs_pkg::PH_DONE;
                     end
                  end
               end
               tpcs_pkg::PH_J3: begin
                  if (hit) begin
                     ex_type_in = tpcs_pkg::TYPE_PES;
                     ex_id_in   = data_in;
                     phase_in   = tpcs_pkg::PH_DONE;
                  end
               end
               tpcs_pkg::PH_SEC: begin
                  if (hit) begin
                     ex_type_in = tpcs_pkg::TYPE_SECTION;
                     ex_id_in   = data_in;
                     phase_in   = tpcs_pkg::PH_DONE;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= tpcs_pkg::PH_DONE;
         ex_set_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         ex_set_ff <= ex_set_in;
      end
   end

   always_ff @(posedge clock) begin
      tei_ff     <= tei_in;
      pusi_ff    <= pusi_in;
      afc0_ff    <= afc0_in;
      pid_ff     <= pid_in;
      tgt_ff     <= tgt_in;
      ex_type_ff <= ex_type_in;
      ex_id_ff   <= ex_id_in;
   end

   assign result.pid     = pid_in;
   assign result.ex_set  = ex_set_in;
   assign result.ex_type = ex_type_in;
   assign result.ex_id   = ex_id_in;

endmodule
`default_nettype wire

// ===== rtl/tpcs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tpcs_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire tpcs_pkg::req_type req_data,
   input  wire logic              hold,
   input  wire logic              rec_room,
   output logic                   rec_push,
   output tpcs_pkg::rec_type      rec_data
);

   localparam int PL = tpcs_pkg::PACKET_LENGTH;
   localparam int WB = tpcs_pkg::WIN_BITS;
   localparam int PB = tpcs_pkg::POS_BITS;

   logic [7:0]    win_mem [PL];
   logic [7:0]    rdata_ff;
   logic          win_we;
   logic [WB-1:0] win_wa, win_ra;

   logic          locked_ff, locked_in;
   logic [PB-1:0] pos_ff, pos_in;
   logic [PB-1:0] fill_ff, fill_in;
   logic [WB-1:0] head_ff, head_in;
   logic          scanning_ff, scanning_in;
   logic [PB-1:0] scan_idx_ff, scan_idx_in;
   logic [PB-1:0] scan_len_ff, scan_len_in;
   logic          rdv_ff, rdv_in;
   logic          found_ff, found_in;
   logic [PB-1:0] scan_pos_ff, scan_pos_in;
   logic          scan_last_ff, scan_last_in;

   logic          accept;
   logic          feed;
   logic [PB-1:0] feed_pos;
   logic [7:0]    feed_byte;
   tpcs_pkg::parse_res_type parse_res;

   logic [WB:0]   wr_sum, sc_sum;
   logic [WB-1:0] wr_addr, sc_addr, head_step;
   logic [PB-1:0] p_after;
   logic          pkt;
   logic          lock_hit;

   assign req_full = hold || scanning_ff || !rec_room;
   assign accept   = req_push && !req_full;

   assign wr_sum    = {1'b0, head_ff} + (WB + 1)'(fill_ff);
   assign wr_addr   = (wr_sum >= (WB + 1)'(PL)) ? WB'(wr_sum - (WB + 1)'(PL)) : wr_sum[WB-1:0];
   assign sc_sum    = {1'b0, head_ff} + (WB + 1)'(scan_idx_ff);
   assign sc_addr   = (sc_sum >= (WB + 1)'(PL)) ? WB'(sc_sum - (WB + 1)'(PL)) : sc_sum[WB-1:0];
   assign head_step = (head_ff == WB'(PL - 1)) ? '0 : head_ff + 1'b1;
   // rdata_ff holds the oldest window byte whenever no scan runs
   assign lock_hit  = (fill_ff == PB'(PL)) && (rdata_ff == tpcs_pkg::SYNC_BYTE)
                      && (req_data.data_byte == tpcs_pkg::SYNC_BYTE);

   always_comb begin
      locked_in    = locked_ff;
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      scanning_in  = scanning_ff;
      scan_idx_in  = scan_idx_ff;
      scan_len_in  = scan_len_ff;
      rdv_in       = 1'b0;
      found_in     = found_ff;
      scan_pos_in  = scan_pos_ff;
      scan_last_in = scan_last_ff;
      win_we       = 1'b0;
      win_wa       = wr_addr;
      feed         = 1'b0;
      feed_pos     = pos_ff;
      feed_byte    = req_data.data_byte;
      rec_push     = 1'b0;
      rec_data     = '0;
      p_after      = pos_ff;
      pkt          = 1'b0;

      if (accept && locked_ff) begin
         if (pos_ff == '0) begin
            if (req_data.data_byte == tpcs_pkg::SYNC_BYTE) begin
               feed    = 1'b1;
               p_after = PB'(1);
            end
         end else begin
            feed    = 1'b1;
            p_after = pos_ff + 1'b1;
         end
         if (p_after == PB'(PL)) begin
            pkt     = 1'b1;
            p_after = '0;
         end else if (req_data.last_of_buffer && p_after >= PB'(4)) begin
            pkt = 1'b1;
         end
         pos_in = p_after;
         if (req_data.last_of_buffer) begin
            locked_in = 1'b0;
            pos_in    = '0;
            fill_in   = '0;
         end
         if (pkt || req_data.last_of_buffer) begin
            rec_push      = 1'b1;
            rec_data.pkt  = pkt;
            rec_data.done = req_data.last_of_buffer;
            rec_data.res  = pkt ? parse_res : '0;
         end
      end else if (accept) begin
         if (lock_hit || req_data.last_of_buffer) begin
            scanning_in  = 1'b1;
            scan_idx_in  = '0;
            found_in     = 1'b0;
            scan_pos_in  = '0;
            scan_last_in = req_data.last_of_buffer;
         end
         if (fill_ff == PB'(PL)) begin
            scan_len_in = PB'(PL);
            if (lock_hit) begin
               locked_in = !req_data.last_of_buffer;
               pos_in    = req_data.last_of_buffer ? '0 : PB'(1);
               fill_in   = '0;
            end else begin
               win_we  = 1'b1;
               win_wa  = head_ff;
               head_in = head_step;
               if (req_data.last_of_buffer) begin
                  fill_in = '0;
               end
            end
         end else begin
            win_we      = 1'b1;
            fill_in     = req_data.last_of_buffer ? '0 : fill_ff + 1'b1;
            scan_len_in = fill_ff + 1'b1;
         end
      end else if (scanning_ff) begin
         if (scan_idx_ff < scan_len_ff) begin
            rdv_in      = 1'b1;
            scan_idx_in = scan_idx_ff + 1'b1;
         end
         if (rdv_ff) begin
            feed_byte = rdata_ff;
            if (found_ff) begin
               feed        = 1'b1;
               feed_pos    = scan_pos_ff;
               scan_pos_in = scan_pos_ff + 1'b1;
            end else if (rdata_ff == tpcs_pkg::SYNC_BYTE) begin
               feed        = 1'b1;
               feed_pos    = '0;
               found_in    = 1'b1;
               scan_pos_in = PB'(1);
            end
         end
         if (scan_idx_ff == scan_len_ff && !rdv_ff) begin
            scanning_in   = 1'b0;
            pkt           = found_ff && (scan_pos_ff >= PB'(4));
            rec_push      = 1'b1;
            rec_data.pkt  = pkt;
            rec_data.done = scan_last_ff;
            rec_data.res  = pkt ? parse_res : '0;
         end
      end

      win_ra = scanning_ff ? sc_addr : head_in;
   end

   tpcs_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .feed    (feed),
      .pos     (feed_pos),
      .data_in (feed_byte),
      .result  (parse_res)
   );

   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_wa] <= req_data.data_byte;
      end
      rdata_ff <= win_mem[win_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff   <= 1'b0;
         pos_ff      <= '0;
         fill_ff     <= '0;
         head_ff     <= '0;
         scanning_ff <= 1'b0;
         rdv_ff      <= 1'b0;
      end else begin
         locked_ff   <= locked_in;
         pos_ff      <= pos_in;
         fill_ff     <= fill_in;
         head_ff     <= head_in;
         scanning_ff <= scanning_in;
         rdv_ff      <= rdv_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      scan_len_ff  <= scan_len_in;
      found_ff     <= found_in;
      scan_pos_ff  <= scan_pos_in;
      scan_last_ff <= scan_last_in;
   end

endmodule
`default_nettype wire

// ===== rtl/tpcs_rec_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tpcs_rec_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire tpcs_pkg::rec_type push_data,
   output logic                   room,
   input  wire logic              pop,
   output logic                   not_empty,
   output tpcs_pkg::rec_type      head_data
);

   tpcs_pkg::rec_type slot_ff [4];
   logic [1:0] rd_ff, wr_ff;
   logic [2:0] cnt_ff, cnt_in;

   assign room      = (cnt_ff != 3'd4);
   assign not_empty = (cnt_ff != 3'd0);
   assign head_data = slot_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/tpcs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tpcs_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rec_valid,
   input  wire tpcs_pkg::rec_type rec_data,
   output logic                   rec_pop,
   output logic                   clearing,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output tpcs_pkg::rsp_type      rsp_data
);

   localparam int IB = tpcs_pkg::PID_BITS;
   localparam int CB = tpcs_pkg::COUNT_BITS;

   tpcs_pkg::tbl_entry_type tbl_mem [tpcs_pkg::PID_ENTRIES];
   tpcs_pkg::tbl_entry_type tbl_rd_ff, tbl_wd, upd;
   logic                    tbl_we;
   logic [IB-1:0]           tbl_wa;

   tpcs_pkg::back_state_type state_ff, state_in;
   logic [IB-1:0]     clr_ff;
   tpcs_pkg::rec_type cur_ff;
   logic              found_ff, found_in;

   tpcs_pkg::rsp_type oq_ff [2];
   logic              oq_rd_ff, oq_wr_ff;
   logic [1:0]        oq_cnt_ff, oq_cnt_in;
   logic              oq_room, oq_push, oq_pop;
   tpcs_pkg::rsp_type res;
   logic              newly;

   assign oq_room   = (oq_cnt_ff != 2'd2);
   assign oq_pop    = rsp_pop && (oq_cnt_ff != 2'd0);
   assign rsp_empty = (oq_cnt_ff == 2'd0);
   assign rsp_data  = oq_ff[oq_rd_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpcs_pkg::BK_CLEAR: begin
            if (clr_ff == IB'(tpcs_pkg::PID_ENTRIES - 1)) begin
               state_in = tpcs_pkg::BK_IDLE;
            end
         end
         tpcs_pkg::BK_IDLE: begin
            if (rec_valid && oq_room) begin
               state_in = tpcs_pkg::BK_UPDATE;
            end
         end
         tpcs_pkg::BK_UPDATE: state_in = tpcs_pkg::BK_IDLE;
         default:             state_in = tpcs_pkg::BK_CLEAR;
      endcase
   end

   // update of the looked-up entry
   always_comb begin
      newly = (tbl_rd_ff.ctype == tpcs_pkg::TYPE_NONE)
              || (tbl_rd_ff.ctype == tpcs_pkg::TYPE_UNKNOWN);
      upd = tbl_rd_ff;
      if (tbl_rd_ff.count != {CB{1'b1}}) begin
         upd.count = tbl_rd_ff.count + 1'b1;
      end
      if (newly && cur_ff.res.ex_set) begin
         upd.ctype = cur_ff.res.ex_type;
         if (cur_ff.res.ex_type == tpcs_pkg::TYPE_SECTION
             || cur_ff.res.ex_type == tpcs_pkg::TYPE_PES) begin
            upd.cid = cur_ff.res.ex_id;
         end
      end
      res = '0;
      if (cur_ff.pkt) begin
         res.record_valid   = 1'b1;
         res.packet_pid     = 13'(cur_ff.res.pid);
         res.packet_count   = tpcs_pkg::COUNT_OUT'(upd.count);
         res.content_type   = upd.ctype;
         res.content_id     = (upd.ctype == tpcs_pkg::TYPE_SECTION
                               || upd.ctype == tpcs_pkg::TYPE_PES) ? upd.cid : 8'd0;
         res.newly_examined = newly;
      end
      found_in = found_ff || (cur_ff.pkt && newly);
      if (cur_ff.done) begin
         res.buffer_done  = 1'b1;
         res.buffer_found = found_in;
      end
   end

   // outputs
   always_comb begin
      rec_pop  = 1'b0;
      clearing = 1'b0;
      tbl_we   = 1'b0;
      tbl_wa   = cur_ff.res.pid;
      tbl_wd   = upd;
      oq_push  = 1'b0;
      case (state_ff)
         tpcs_pkg::BK_CLEAR: begin
            clearing = 1'b1;
            tbl_we   = 1'b1;
            tbl_wa   = clr_ff;
            tbl_wd   = '0;
         end
         tpcs_pkg::BK_IDLE: begin
            rec_pop = rec_valid && oq_room;
         end
         tpcs_pkg::BK_UPDATE: begin
            tbl_we  = cur_ff.pkt;
            oq_push = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      oq_cnt_in = oq_cnt_ff;
      if (oq_push && !oq_pop) begin
         oq_cnt_in = oq_cnt_ff + 1'b1;
      end else if (oq_pop && !oq_push) begin
         oq_cnt_in = oq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_wa] <= tbl_wd;
      end
      tbl_rd_ff <= tbl_mem[rec_data.res.pid];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tpcs_pkg::BK_CLEAR;
         clr_ff    <= '0;
         found_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_wr_ff  <= 1'b0;
         oq_cnt_ff <= '0;
      end else begin
         state_ff  <= state_in;
         oq_cnt_ff <= oq_cnt_in;
         if (state_ff == tpcs_pkg::BK_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (oq_push) begin
            found_ff <= cur_ff.done ? 1'b0 : found_in;
            oq_wr_ff <= !oq_wr_ff;
         end
         if (oq_pop) begin
            oq_rd_ff <= !oq_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rec_pop) begin
         cur_ff <= rec_data;
      end
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= res;
      end
   end

endmodule
`default_nettype wire

// ===== tb/pid_scan_checker.sv =====
`timescale 1ns / 1ps
module pid_scan_checker import tpcs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  logic    req_full,
   input  req_type req_data,
   input  logic    rsp_empty,
   input  logic    rsp_pop,
   input  rsp_type rsp_data,
   output int      errors,
   output int      pending,
   output int      checked
);

   localparam int unsigned CNT_MAX = (1 << COUNT_BITS) - 1;

   int unsigned pid_cnt [PID_ENTRIES];
   logic [2:0]  pid_typ [PID_ENTRIES];
   logic [7:0]  pid_cid [PID_ENTRIES];
   logic [7:0]  win [PACKET_LENGTH];
   bit          locked;
   int          pos;
   int          fill;
   bit          found;

   rsp_type expected_records[$];

   function automatic int win_at(int idx, int len);
      if (idx >= len || idx >= PACKET_LENGTH) return -1;
      return int'(win[idx]);
   endfunction

   // header and payload start decide the content type of a fresh PID
   function automatic void classify(int len, logic [12:0] pid);
      logic [7:0] b1, b3;
      int j, v, v0;
      bit pes;
      b1 = win[1];
      b3 = win[3];
      if (b1[7]) return;
      if (b3[7:6] != 0) begin
         pid_typ[pid] = TYPE_SCRAMBLED;
         return;
      end
      if (b1[6]) begin
         pid_typ[pid] = TYPE_UNKNOWN;
         j = 4;
         if (b3[5]) begin
            v = win_at(j, len);
            if (v < 0) return;
            j += v + 1;
         end
         if (b3[4]) begin
            pes = 0;
            v0 = win_at(j, len);
            if (v0 < 0) return;
            if (v0 == 0) begin
               v = win_at(j + 1, len);
               if (v < 0) return;
               if (v == 0) begin
                  v = win_at(j + 2, len);
                  if (v < 0) return;
                  if (v == 1) pes = 1;
               end
            end
            if (pes) v = win_at(j + 3, len);
            else v = win_at(j + v0 + 1, len);
            if (v < 0) return;
            pid_typ[pid] = pes ? TYPE_PES : TYPE_SECTION;
            pid_cid[pid] = v[7:0];
         end
         return;
      end
      if (pid == STUFF_PID) pid_typ[pid] = TYPE_STUFFING;
   endfunction

   function automatic void count_packet(int len, inout rsp_type r);
      logic [12:0] pid;
      logic [2:0]  t;
      bit          fresh;
      pid = {win[1][4:0], win[2]};
      t = pid_typ[pid];
      fresh = (t == TYPE_NONE || t == TYPE_UNKNOWN);
      if (pid_cnt[pid] < CNT_MAX) pid_cnt[pid]++;
      if (fresh) begin
         found = 1;
         classify(len, pid);
      end
      t = pid_typ[pid];
      r.record_valid   = 1;
      r.packet_pid     = pid;
      r.packet_count   = pid_cnt[pid][23:0];
      r.content_type   = t;
      r.content_id     = (t == TYPE_SECTION || t == TYPE_PES) ? pid_cid[pid] : 8'd0;
      r.newly_examined = fresh;
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic last);
      rsp_type r;
      bit have;
      int k, m;
      r = '0;
      have = 0;
      if (!locked) begin
         if (fill >= PACKET_LENGTH) begin
            if (win[0] == SYNC_BYTE && b == SYNC_BYTE) begin
               count_packet(PACKET_LENGTH, r);
               have = 1;
               locked = 1;
               win[0] = b;
               pos = 1;
               fill = 0;
            end else begin
               for (k = 0; k < PACKET_LENGTH - 1; k++) win[k] = win[k+1];
               win[PACKET_LENGTH-1] = b;
            end
         end else begin
            win[fill] = b;
            fill++;
         end
         if (last && !locked) begin
            for (k = 0; k < fill; k++)
               if (win[k] == SYNC_BYTE) break;
            if (k < fill) begin
               m = fill - k;
               for (int i = 0; i < m; i++) win[i] = win[i+k];
               if (m >= 4) begin
                  count_packet(m, r);
                  have = 1;
               end
            end
         end
      end else begin
         if (pos == 0) begin
            if (b == SYNC_BYTE) begin
               win[0] = b;
               pos = 1;
            end
         end else if (pos < PACKET_LENGTH) begin
            win[pos] = b;
            pos++;
         end
         if (pos >= PACKET_LENGTH) begin
            count_packet(PACKET_LENGTH, r);
            have = 1;
            pos = 0;
         end else if (last && pos >= 4) begin
            count_packet(pos, r);
            have = 1;
         end
      end
      if (last) begin
         r.buffer_done  = 1;
         r.buffer_found = found;
         found  = 0;
         locked = 0;
         pos    = 0;
         fill   = 0;
         have   = 1;
      end
      if (have) expected_records.push_back(r);
   endfunction

   assign pending = expected_records.size();

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int i = 0; i < PID_ENTRIES; i++) begin
            pid_cnt[i] = 0;
            pid_typ[i] = TYPE_NONE;
            pid_cid[i] = 0;
         end
         locked = 0;
         pos    = 0;
         fill   = 0;
         found  = 0;
         errors  <= 0;
         checked <= 0;
         expected_records.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_records.size() == 0) begin
               if (errors < 10)
                  $display("%0t: unexpected result transaction %p", $realtime, rsp_data);
               errors <= errors + 1;
            end else begin
               e = expected_records.pop_front();
               checked <= checked + 1;
               if (e.record_valid !== rsp_data.record_valid
                   || e.packet_pid !== rsp_data.packet_pid
                   || e.packet_count !== rsp_data.packet_count
                   || e.content_type !== rsp_data.content_type
                   || e.content_id !== rsp_data.content_id
                   || e.newly_examined !== rsp_data.newly_examined
                   || e.buffer_done !== rsp_data.buffer_done
                   || e.buffer_found !== rsp_data.buffer_found) begin
                  if (errors < 10)
                     $display("%0t: mismatch exp %p got %p", $realtime, e, rsp_data);
                  errors <= errors + 1;
               end
            end
         end
         // predict after popping so a same-cycle result is never compared early
         if (req_push && !req_full)
            predict_byte(req_data.data_byte, req_data.last_of_buffer);
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import tpcs_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_data;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;
   int      errors, pending, checked;

   int tx_idle;
   int rx_idle;
   int hold_asks;
   int items;
   byte unsigned stream[$];

   ts_pid_content_scanner DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   pid_scan_checker checker_i (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .errors(errors), .pending(pending), .checked(checked)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      #60ms;
      $display("FAILED: results differ");
      $finish;
   end

   // receiver: random pops, with a long counted hold-off on request
   initial begin
      int hold_cnt, hold_seen;
      hold_cnt = 0;
      hold_seen = 0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_cnt = 600;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_pop = 1'b0;
         end else begin
            rsp_pop = ($urandom_range(99) >= rx_idle);
         end
      end
   end

   task automatic send_byte(byte unsigned b, bit last);
      while ($urandom_range(99) < tx_idle) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push = 1'b1;
      req_data.data_byte = b;
      req_data.last_of_buffer = last;
      while (req_full) @(negedge clock);
      @(negedge clock);
      req_push = 1'b0;
      items++;
   endtask

   task automatic send_stream();
      for (int i = 0; i < stream.size(); i++)
         send_byte(stream[i], i == stream.size() - 1);
      stream.delete();
   endtask

   // one packet: flags, adaptation field, PES or section start or none, cut to len bytes
   task automatic add_packet(logic [12:0] pid, int len);
      byte unsigned pkt[$];
      bit pusi, tei;
      logic [1:0] sc, afc;
      int al;
      tei  = ($urandom_range(9) == 0);
      pusi = ($urandom_range(9) < 7);
      sc   = ($urandom_range(7) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
      afc  = 2'($urandom);
      pkt.push_back(SYNC_BYTE);
      pkt.push_back({tei, pusi, 1'b0, pid[12:8]});
      pkt.push_back(pid[7:0]);
      pkt.push_back({sc, afc, 4'($urandom)});
      if (afc[1]) begin
         al = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(10);
         pkt.push_back(al);
         repeat (al) pkt.push_back($urandom_range(255));
      end
      case ($urandom_range(2))
         0: begin
            pkt.push_back(0); pkt.push_back(0); pkt.push_back(1);
            pkt.push_back($urandom_range(255));
         end
         1: begin
            al = $urandom_range(4);
            pkt.push_back(al);
            repeat (al) pkt.push_back($urandom_range(255));
            pkt.push_back($urandom_range(255));
         end
         default: ;
      endcase
      while (pkt.size() < PACKET_LENGTH) pkt.push_back($urandom_range(255));
      for (int i = 0; i < len && i < PACKET_LENGTH; i++) stream.push_back(pkt[i]);
   endtask

   function automatic logic [12:0] pick_pid();
      case ($urandom_range(4))
         0: return 13'h1FFF;
         1: return 13'h0000;
         default: return 13'($urandom_range(15)) << $urandom_range(9);
      endcase
   endfunction

   initial begin
      int n_bufs;
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      tx_idle = 30;
      rx_idle = 64;
      hold_asks = 0;
      items = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: lone sync, too-short packet, cut references, extreme bytes
      stream = '{8'h47};
      send_stream();
      stream = '{8'h00, 8'h47, 8'h1F, 8'hFF};
      send_stream();
      stream = '{8'hFF, 8'h47, 8'h1F, 8'hFF, 8'h10};
      send_stream();
      stream = '{8'h47, 8'h40, 8'h11, 8'h30, 8'h07};
      send_stream();
      stream = '{8'h47, 8'h40, 8'h12, 8'h10, 8'h00, 8'h00};
      send_stream();
      stream = '{8'h47, 8'h40, 8'h12, 8'h10, 8'h00, 8'h00, 8'h01, 8'hE0};
      send_stream();
      stream = '{8'h47, 8'h40, 8'h13, 8'h10, 8'h02, 8'hAA, 8'hBB, 8'h42};
      send_stream();
      stream = '{8'h47, 8'hC0, 8'h14, 8'h10, 8'h00};
      send_stream();
      stream = '{8'h47, 8'h40, 8'h15, 8'hD0, 8'h00};
      send_stream();
      stream = '{8'h47, 8'h1F, 8'hFF, 8'h10, 8'h55};
      send_stream();
      // lock on the second sync, a locked packet, then a cut locked packet
      add_packet(13'h0100, PACKET_LENGTH);
      add_packet(13'h0100, PACKET_LENGTH);
      add_packet(13'h1FFF, 20);
      send_stream();

      n_bufs = 0;
      while (n_bufs < 24) begin
         if (n_bufs == 0) begin
            tx_idle = 64;
            rx_idle = 30;
         end else if (n_bufs == 8) begin
            tx_idle = 0;
            rx_idle = 0;
         end
         if (n_bufs == 12) hold_asks++;
         if (n_bufs == 20)
            while (pending != 0) @(negedge clock);
         if ($urandom_range(2) == 0) repeat ($urandom_range(2)) stream.push_back($urandom);
         add_packet(pick_pid(), $urandom_range(1, 8));
         send_stream();
         n_bufs++;
      end
      req_push = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (errors == 0 && pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== ts_pid_content_scanner.f =====
rtl/tpcs_pkg.sv
rtl/tpcs_parser.sv
rtl/tpcs_front.sv
rtl/tpcs_rec_queue.sv
rtl/tpcs_back.sv
rtl/ts_pid_content_scanner.sv
tb/pid_scan_checker.sv
tb/testbench.sv
